@@ sv/plti_pkg.sv @@
// Types and constants shared by the piecewise-linear table interpolator.
// No dependencies; compile first.
`timescale 1ns / 1ps

package plti_pkg;

    typedef logic signed [15:0] angle_t;
    typedef logic signed [15:0] value_t;
    typedef logic [1:0]         cmd_t;
    typedef logic [1:0]         status_t;

    // Commands
    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_APPEND = 2'd1;
    localparam cmd_t CMD_QUERY  = 2'd2;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Restoring divider: 32-bit numerator, 16-bit divisor, one bit per cycle
    localparam int DIV_STEPS  = 32;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_SUM,
        S_DONE
    } plti_state_t;

endpackage

@@ sv/plti_if.sv @@
// Valid/ready channel interfaces for the interpolator: request and response.
// Depends on plti_pkg.
`timescale 1ns / 1ps

interface plti_req_if;
    import plti_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   command;
    angle_t angle;
    value_t point_value;

    modport source (output valid, output command, output angle, output point_value,
                    input ready);
    modport sink   (input valid, input command, input angle, input point_value,
                    output ready);
endinterface

interface plti_rsp_if;
    import plti_pkg::*;

    logic    valid;
    logic    ready;
    value_t  result_value;
    status_t status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

@@ sv/piecewise_linear_table_interpolator.sv @@
// Piecewise-linear lookup table: breakpoint store, scan sequencer, divider.
// Depends on plti_pkg and the channel interfaces in plti_if.sv.
`timescale 1ns / 1ps

// Usage
// - req channel carries one item: command (clear / append / query), angle in
//   hundredths of a degree and point_value in Q4.12 (append only).
// - rsp channel returns exactly one item per request: result_value (Q4.12,
//   zero unless status is ok) and status (ok, empty, out of range, full).
// - Breakpoints sit in a MAX_POINTS-deep memory with a registered read port;
//   appends must arrive in ascending angle order (not checked).
// - req.ready is high only while the sequencer is idle; one item at a time.
// - Clear, append, unused command, empty-table query: idle goes straight to the
//   final state, which loads the output register and returns to idle.
// - Query: fetch last and first breakpoint (range check), then one scan step
//   per breakpoint walked, one memory read each. An interpolated result adds a
//   multiply step, a restoring divide (one quotient bit per cycle) and an
//   add/saturate step.
// - Output register decouples the sides: a new item is accepted while an older
//   result waits; if the receiver stalls, the sequencer parks in its final
//   state until the output register frees up.
// - Reset empties the table (count to zero) and clears the output valid.
//   Memory contents are not cleared; only entries below the count are read.

module piecewise_linear_table_interpolator #(
    parameter int MAX_POINTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    plti_req_if.sink   req,
    plti_rsp_if.source rsp
);
    import plti_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // Sequencer and control
    plti_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;    // index of the entry in rd_*_reg
    logic             out_valid_reg, out_valid_next;

    // Breakpoint memory
    angle_t mem_x [MAX_POINTS];
    value_t mem_y [MAX_POINTS];
    angle_t rd_x_reg;
    value_t rd_y_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    // Query datapath
    angle_t x_reg, x_next;
    angle_t last_x_reg, last_x_next;
    value_t last_y_reg, last_y_next;
    angle_t xa_reg, xa_next;
    value_t ya_reg, ya_next;
    logic signed [16:0] dx_reg, dx_next;
    logic signed [16:0] dy_reg, dy_next;
    logic signed [16:0] den_reg, den_next;
    logic [15:0] den_mag_reg, den_mag_next;
    logic        neg_reg, neg_next;
    logic [31:0] div_reg, div_next;         // numerator in, quotient out
    logic [15:0] rem_reg, rem_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    value_t  res_val_reg, res_val_next;
    status_t res_st_reg, res_st_next;
    value_t  out_val_reg, out_val_next;
    status_t out_st_reg, out_st_next;

    logic             slot_free;
    logic             full;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] ptr_inc;
    logic             more;
    logic             out_of_range;

    logic [15:0] dx_mag, dy_mag;
    logic [31:0] product;
    logic [16:0] rem_sh, rem_sub;
    logic        rem_ge;
    logic signed [32:0] quot_s;
    logic signed [33:0] sum_s;
    value_t             sum_sat;

    function automatic logic [15:0] mag17(input logic signed [16:0] v);
        logic signed [16:0] n;
        n = -v;
        return v[16] ? n[15:0] : v[15:0];
    endfunction

    assign slot_free    = !out_valid_reg || rsp.ready;
    assign full         = (count_reg == CNT_W'(MAX_POINTS));
    assign cnt_m1       = count_reg - CNT_W'(1);
    assign ptr_inc      = CNT_W'(ptr_reg) + CNT_W'(1);
    assign more         = (ptr_inc < count_reg);
    assign out_of_range = (x_reg < rd_x_reg) || (x_reg > last_x_reg);

    // Multiply: product of the magnitudes of the deltas
    assign dx_mag  = mag17(dx_reg);
    assign dy_mag  = mag17(dy_reg);
    assign product = dx_mag * dy_mag;

    // One restoring-division step
    assign rem_sh  = {rem_reg, div_reg[31]};
    assign rem_sub = rem_sh - {1'b0, den_mag_reg};
    assign rem_ge  = (rem_sh >= {1'b0, den_mag_reg});

    // Apply sign, add base value, saturate
    assign quot_s = neg_reg ? -$signed({1'b0, div_reg}) : $signed({1'b0, div_reg});
    assign sum_s  = $signed({{18{ya_reg[15]}}, ya_reg}) + $signed({quot_s[32], quot_s});
    always_comb
    begin
        if (sum_s > 34'sd32767)
        begin
            sum_sat = 16'sh7FFF;
        end
        else if (sum_s < -34'sd32768)
        begin
            sum_sat = 16'sh8000;
        end
        else
        begin
            sum_sat = sum_s[15:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.command == CMD_QUERY && count_reg != '0)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LAST:
            begin
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                if (out_of_range || x_reg == rd_x_reg || count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (x_reg < rd_x_reg)
                begin
                    state_next = (rd_x_reg == xa_reg) ? S_DONE : S_MUL;
                end
                else if (x_reg == rd_x_reg || !more)
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        req.ready      = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = ptr_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        den_next       = den_reg;
        den_mag_next   = den_mag_reg;
        neg_next       = neg_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    x_next       = req.angle;
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr  = cnt_m1[IDX_W-1:0];
                                ptr_next = cnt_m1[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LAST:
            begin
                last_x_next = rd_x_reg;
                last_y_next = rd_y_reg;
                rd_addr     = '0;
                ptr_next    = '0;
            end
            S_FIRST:
            begin
                xa_next = rd_x_reg;
                ya_next = rd_y_reg;
                if (out_of_range)
                begin
                    res_st_next = ST_RANGE;
                end
                else if (x_reg == rd_x_reg)
                begin
                    res_val_next = rd_y_reg;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    res_val_next = last_y_reg;
                end
                else
                begin
                    rd_addr  = IDX_W'(1);
                    ptr_next = IDX_W'(1);
                end
            end
            S_SCAN:
            begin
                if (x_reg < rd_x_reg)
                begin
                    // bracketed between entry ptr-1 (a) and entry ptr (b)
                    dx_next  = {x_reg[15], x_reg} - {xa_reg[15], xa_reg};
                    dy_next  = {rd_y_reg[15], rd_y_reg} - {ya_reg[15], ya_reg};
                    den_next = {rd_x_reg[15], rd_x_reg} - {xa_reg[15], xa_reg};
                    if (rd_x_reg == xa_reg)
                    begin
                        res_val_next = ya_reg;
                    end
                end
                else
                begin
                    xa_next = rd_x_reg;
                    ya_next = rd_y_reg;
                    if (x_reg == rd_x_reg)
                    begin
                        res_val_next = rd_y_reg;
                    end
                    else if (more)
                    begin
                        rd_addr  = ptr_inc[IDX_W-1:0];
                        ptr_next = ptr_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        res_val_next = last_y_reg;
                    end
                end
            end
            S_MUL:
            begin
                div_next     = product;
                den_mag_next = mag17(den_reg);
                neg_next     = dx_reg[16] ^ dy_reg[16] ^ den_reg[16];
                rem_next     = '0;
                step_next    = DIV_STEP_W'(DIV_STEPS - 1);
            end
            S_DIV:
            begin
                rem_next  = rem_ge ? rem_sub[15:0] : rem_sh[15:0];
                div_next  = {div_reg[30:0], rem_ge};
                step_next = step_reg - DIV_STEP_W'(1);
            end
            S_SUM:
            begin
                res_val_next = sum_sat;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        x_reg       <= x_next;
        last_x_reg  <= last_x_next;
        last_y_reg  <= last_y_next;
        xa_reg      <= xa_next;
        ya_reg      <= ya_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        den_reg     <= den_next;
        den_mag_reg <= den_mag_next;
        neg_reg     <= neg_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    // Breakpoint memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= req.angle;
            mem_y[count_reg[IDX_W-1:0]] <= req.point_value;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.status       = out_st_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("breakpoint count above table depth");

    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_value == '0))
        else $error("nonzero value with non-ok status");

    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.command != CMD_QUERY) |=> (state_reg == S_DONE))
        else $error("non-query item did not finish in one cycle");

    a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(req.valid && req.ready))
        else $error("count changed without an accepted item");

endmodule

@@ tb/sv/tb_piecewise_linear_table_interpolator.sv @@
// Self-checking testbench for the piecewise-linear table interpolator.
// Depends on plti_pkg, the channel interfaces in plti_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interpolator;
    import plti_pkg::*;

    localparam int   TABLE_DEPTH  = 32;
    localparam int   ANGLE_LIMIT  = 18000;     // hundredths of a degree
    localparam int   RANDOM_ITEMS = 1050;
    localparam int   MAX_REPORTS  = 10;
    localparam cmd_t CMD_UNUSED   = 2'd3;      // no-op command, still answered

    typedef struct {
        cmd_t   command;
        angle_t angle;
        value_t point_value;
    } request_t;

    typedef struct {
        value_t  value;
        status_t status;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n;

    plti_req_if req ();
    plti_rsp_if rsp ();

    piecewise_linear_table_interpolator #(
        .MAX_POINTS (TABLE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the breakpoint table, updated in acceptance order.
    // ------------------------------------------------------------------
    angle_t table_angle [TABLE_DEPTH];
    value_t table_value [TABLE_DEPTH];
    int     table_count = 0;

    request_t       pending_requests[$];   // items not yet offered to the block
    lookup_result_t expected_results[$];   // answers owed by the block, oldest first
    int             gen_points[$];         // angles appended so far, used to aim queries

    request_t in_flight;
    int       total_requests    = 0;
    int       requests_accepted = 0;
    int       mismatch_count    = 0;
    int       send_gap          = 0;
    int       recv_gap          = 0;
    bit       send_burst        = 1'b0;
    bit       recv_burst        = 1'b0;

    function automatic int random_angle();
        return int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    endfunction

    function automatic int random_value();
        case ($urandom_range(0, 7))
            0:       return int'($urandom_range(0, 127)) - 64;
            1:       return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Idle cycles before the next item; zero throughout a burst stretch.
    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic void queue_item(input cmd_t c, input int a, input int v);
        request_t it;
        it.command     = c;
        it.angle       = angle_t'(a);
        it.point_value = value_t'(v);
        pending_requests.push_back(it);
    endfunction

    // Executes one accepted item on the shadow table and records the answer.
    // The query path mirrors the block: range check against first and last
    // entry, then a forward scan; exact hits win over interpolation, and the
    // first matching entry wins among duplicates.
    function automatic void apply_to_table(input request_t it);
        lookup_result_t r;
        longint         num, den, total;
        bit             found;
        int             q;
        r.value  = '0;
        r.status = ST_OK;
        case (it.command)
            CMD_CLEAR:  table_count = 0;
            CMD_APPEND:
            begin
                if (table_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    table_angle[table_count] = it.angle;
                    table_value[table_count] = it.point_value;
                    table_count++;
                end
            end
            CMD_QUERY:
            begin
                if (table_count == 0)
                    r.status = ST_EMPTY;
                else if (it.angle < table_angle[0] || it.angle > table_angle[table_count - 1])
                    r.status = ST_RANGE;
                else
                begin
                    found = 1'b0;
                    for (q = 0; q < table_count && !found; q++)
                    begin
                        if (it.angle == table_angle[q])
                        begin
                            r.value = table_value[q];
                            found   = 1'b1;
                        end
                        else if (q + 1 < table_count && it.angle < table_angle[q + 1])
                        begin
                            den = longint'(table_angle[q + 1]) - longint'(table_angle[q]);
                            num = (longint'(it.angle) - longint'(table_angle[q]))
                                * (longint'(table_value[q + 1]) - longint'(table_value[q]));
                            if (den == 0)
                                r.value = table_value[q];
                            else
                            begin
                                // SV division truncates toward zero
                                total = longint'(table_value[q]) + num / den;
                                if (total > 32767)
                                    total = 32767;
                                else if (total < -32768)
                                    total = -32768;
                                r.value = value_t'(total);
                            end
                            found = 1'b1;
                        end
                    end
                    // no bracketing pair: fall back to the last entry
                    if (!found)
                        r.value = table_value[table_count - 1];
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: holds an item until accepted, then idles a drawn
    // number of cycles before offering the next one.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.command     <= CMD_CLEAR;
            req.angle       <= '0;
            req.point_value <= '0;
            send_gap         = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                apply_to_table(in_flight);
                requests_accepted++;
            end
            if (req.valid && !req.ready)
                ;   // hold the offered item
            else if (send_gap != 0)
            begin
                send_gap--;
                req.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                in_flight        = pending_requests.pop_front();
                req.command     <= in_flight.command;
                req.angle       <= in_flight.angle;
                req.point_value <= in_flight.point_value;
                req.valid       <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = draw_wait(send_burst);
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: checks each accepted item against the oldest
    // expectation and stalls ready for a drawn number of cycles after it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap   = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result value=%0d status=%0d",
                                 $realtime, rsp.result_value, rsp.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.result_value !== want.value || rsp.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch value exp=%0d got=%0d status exp=%0d got=%0d",
                                     $realtime, want.value, rsp.result_value,
                                     want.status, rsp.status);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_gap = draw_wait(recv_burst);
            end
            if (recv_gap != 0)
            begin
                recv_gap--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Watchdog: far above the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset and end-of-run check.
    // ------------------------------------------------------------------
    initial
    begin
        int  seq_no, n, m, i, k, a, b, lo, hi, width, kind;
        bit  sorted, extremes;
        int  pts[$];

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.command     = CMD_CLEAR;
        req.angle       = '0;
        req.point_value = '0;
        rsp.ready       = 1'b0;

        // Directed: empty table, unused command, full-scale span
        queue_item(CMD_QUERY,  -5, 0);
        queue_item(CMD_UNUSED, 12345, -1);
        queue_item(CMD_APPEND, -ANGLE_LIMIT, -32768);
        queue_item(CMD_QUERY,  -ANGLE_LIMIT, 0);          // single point, exact hit
        queue_item(CMD_QUERY,  0, 0);                     // above the only point
        queue_item(CMD_APPEND, ANGLE_LIMIT, 32767);
        queue_item(CMD_QUERY,  ANGLE_LIMIT - 1, 0);       // widest numerator
        queue_item(CMD_QUERY,  -ANGLE_LIMIT + 1, 0);
        queue_item(CMD_QUERY,  ANGLE_LIMIT, 0);
        // Duplicate angle, negative slope with truncation toward zero
        queue_item(CMD_CLEAR,  0, 0);
        queue_item(CMD_APPEND, -100, 4096);
        queue_item(CMD_APPEND, 0, -4095);
        queue_item(CMD_APPEND, 0, 8192);
        queue_item(CMD_APPEND, 100, 0);
        queue_item(CMD_QUERY,  0, 0);                     // first duplicate wins
        queue_item(CMD_QUERY,  -50, 0);
        queue_item(CMD_QUERY,  50, 0);
        queue_item(CMD_QUERY,  -101, 0);
        queue_item(CMD_QUERY,  101, 0);
        // Unsorted table
        queue_item(CMD_CLEAR,  0, 0);
        queue_item(CMD_APPEND, 0, 100);
        queue_item(CMD_APPEND, 300, 200);
        queue_item(CMD_APPEND, 100, 300);
        queue_item(CMD_APPEND, 200, 400);
        queue_item(CMD_QUERY,  150, 0);
        queue_item(CMD_QUERY,  200, 0);
        gen_points = '{0, 300, 100, 200};

        // Random: mostly clear / ascending appends / aimed queries, some noise.
        // Every tenth sequence appends 32 to 35 points, filling the table or pushing it past full.
        seq_no = 0;
        while (pending_requests.size() < RANDOM_ITEMS + 26)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                case ($urandom_range(0, 3))
                    0: queue_item(CMD_UNUSED, random_angle(), random_value());
                    1:
                    begin
                        queue_item(CMD_CLEAR, random_angle(), random_value());
                        queue_item(CMD_QUERY, random_angle(), random_value());
                        gen_points.delete();
                    end
                    2:
                    begin
                        a = random_angle();
                        queue_item(CMD_APPEND, a, random_value());
                        gen_points.push_back(a);
                    end
                    default: queue_item(CMD_QUERY, random_angle(), random_value());
                endcase
            end
            else
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    queue_item(CMD_CLEAR, random_angle(), random_value());
                    gen_points.delete();
                end
                n = (seq_no % 10 == 9) ? int'($urandom_range(32, 35))
                                       : int'($urandom_range(1, 8));
                extremes = 1'b0;
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo       = -ANGLE_LIMIT;
                        width    = 2 * ANGLE_LIMIT;
                        extremes = 1'b1;
                    end
                    1:
                    begin
                        // narrow window: duplicates and tiny spans
                        width = $urandom_range(0, 40);
                        lo    = -ANGLE_LIMIT + int'($urandom_range(0, 2 * ANGLE_LIMIT - width));
                    end
                    default:
                    begin
                        width = $urandom_range(100, 2 * ANGLE_LIMIT);
                        lo    = -ANGLE_LIMIT + int'($urandom_range(0, 2 * ANGLE_LIMIT - width));
                    end
                endcase
                sorted = ($urandom_range(0, 9) != 0);
                pts.delete();
                for (i = 0; i < n; i++)
                begin
                    a = lo + int'($urandom_range(0, width));
                    k = pts.size();
                    if (sorted)
                        while (k > 0 && pts[k - 1] > a)
                            k--;
                    pts.insert(k, a);
                end
                if (sorted && extremes && n > 1)
                begin
                    pts[0]     = -ANGLE_LIMIT;
                    pts[n - 1] = ANGLE_LIMIT;
                end
                for (i = 0; i < n; i++)
                begin
                    queue_item(CMD_APPEND, pts[i], random_value());
                    gen_points.push_back(pts[i]);
                end

                m = $urandom_range(2, 8);
                for (i = 0; i < m; i++)
                begin
                    n    = gen_points.size();
                    kind = $urandom_range(0, 99);
                    if (n == 0 || kind >= 90)
                        a = random_angle();
                    else
                    begin
                        lo = gen_points[0];
                        hi = gen_points[n - 1];
                        if (kind < 30)
                            a = gen_points[$urandom_range(0, n - 1)];
                        else if (kind < 65 && n > 1)
                        begin
                            // somewhere between two neighbors
                            k = $urandom_range(0, n - 2);
                            a = gen_points[k];
                            b = gen_points[k + 1];
                            if (a > b)
                            begin
                                k = a;
                                a = b;
                                b = k;
                            end
                            a = a + int'($urandom_range(0, b - a));
                        end
                        else if (kind < 75 && lo > -ANGLE_LIMIT)
                            a = $urandom_range(0, 1) ? lo - 1
                              : lo - 1 - int'($urandom_range(0, lo + ANGLE_LIMIT - 1));
                        else if (kind < 85 && hi < ANGLE_LIMIT)
                            a = $urandom_range(0, 1) ? hi + 1
                              : hi + 1 + int'($urandom_range(0, ANGLE_LIMIT - hi - 1));
                        else
                            a = $urandom_range(0, 1) ? ANGLE_LIMIT : -ANGLE_LIMIT;
                    end
                    queue_item(CMD_QUERY, a, random_value());
                end
            end
            seq_no++;
        end
        total_requests = pending_requests.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every item taken and every answer seen, then a quiet
        // stretch longer than the slowest query to catch stray results.
        while (requests_accepted < total_requests || expected_results.size() != 0)
            @(negedge clk);
        repeat (TABLE_DEPTH + 40) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
